FILE: design/itcu_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt translation command unit package
// Command codes, register indexes, fixed limits and the beat structures
// used by the unit and its testbench.
// ----------------------------------------------------------------------------
package itcu_pkg;

    localparam logic [3:0] OP_MOVI   = 4'd0;
    localparam logic [3:0] OP_SYNC   = 4'd1;
    localparam logic [3:0] OP_MAPD   = 4'd2;
    localparam logic [3:0] OP_MAPC   = 4'd3;
    localparam logic [3:0] OP_MAPTI  = 4'd4;
    localparam logic [3:0] OP_MAPI   = 4'd5;
    localparam logic [3:0] OP_INV    = 4'd6;
    localparam logic [3:0] OP_INVALL = 4'd7;
    localparam logic [3:0] OP_MSI    = 4'd8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CPUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_TABLE = 1'd1;

    localparam logic [31:0] DEV_ID_LIMIT = 32'd65536;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] device_id;
        logic [31:0] event_id;
        logic [31:0] phys_intid;
        logic [15:0] collection_id;
        logic [31:0] target_cpu;
        logic        map_valid_bit;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic        inject_valid;
        logic [3:0]  inject_cpu;
        logic [31:0] inject_intid;
    } rsp_t;

endpackage

FILE: design/itcu_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one decoded command or MSI per beat.
// ----------------------------------------------------------------------------
interface itcu_cmd_if;

    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] device_id;
    logic [31:0] event_id;
    logic [31:0] phys_intid;
    logic [15:0] collection_id;
    logic [31:0] target_cpu;
    logic        map_valid_bit;

    modport source (
        output valid, op, device_id, event_id, phys_intid, collection_id,
               target_cpu, map_valid_bit,
        input  ready
    );

    modport sink (
        input  valid, op, device_id, event_id, phys_intid, collection_id,
               target_cpu, map_valid_bit,
        output ready
    );

endinterface

FILE: design/itcu_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status and injection result per beat.
// ----------------------------------------------------------------------------
interface itcu_rsp_if;

    logic        valid;
    logic        ready;
    logic        status;
    logic        inject_valid;
    logic [3:0]  inject_cpu;
    logic [31:0] inject_intid;

    modport source (
        output valid, status, inject_valid, inject_cpu, inject_intid,
        input  ready
    );

    modport sink (
        input  valid, status, inject_valid, inject_cpu, inject_intid,
        output ready
    );

endinterface

FILE: design/itcu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module itcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/interrupt_translation_command_unit.sv
// ----------------------------------------------------------------------------
// Interrupt translation command unit
// Executes decoded translation commands and resolves MSIs to injections.
//
// Usage:
//   cmd carries one command or MSI per beat; rsp returns exactly one beat
//   per command beat, in order: status, and for a delivered MSI the target
//   CPU and interrupt ID. cfg_we/cfg_index/cfg_data write num_cpus and
//   dev_table_entries; write them only while the unit is idle.
// Sequencing:
//   SYNC, INV, INVALL, MAPD, MAPC, MAPTI, MAPI and unknown codes pass
//   from accept through EXEC and DONE to response valid. MOVI and MSI
//   search the mapping table newest first, one entry per cycle through its
//   RAM read port in SCAN, then CPU_RD after an MSI hit, then DONE, which
//   registers the result; cmd.ready is low from accept, returns with rsp.valid.
// Reset:
//   All collections unmapped, mapping table empty, num_cpus = 1,
//   dev_table_entries = 0. No clearing pass is needed.
// Stall:
//   A stalled rsp holds its beat while the next command runs; that result
//   then waits in its final state and cmd.ready stays low until delivery.
// ----------------------------------------------------------------------------
module interrupt_translation_command_unit #(
    parameter int MAX_CPUS     = 16,
    parameter int MAX_MAPPINGS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    itcu_cmd_if.sink                           cmd,
    itcu_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [itcu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [itcu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int NW   = $clog2(MAX_CPUS + 1);
    localparam int AW   = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1;
    localparam int CNTW = $clog2(MAX_MAPPINGS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CPU_RD,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    itcu_pkg::cmd_t        cmd_reg, cmd_next;
    itcu_pkg::rsp_t        res_reg, res_next;
    itcu_pkg::rsp_t        out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [4:0]            num_cpus_reg, num_cpus_next;
    logic [21:0]           dev_entries_reg, dev_entries_next;
    logic [MAX_CPUS-1:0]   coll_mapped_reg, coll_mapped_next;
    logic [CNTW-1:0]       map_count_reg, map_count_next;
    logic [AW-1:0]         scan_idx_reg, scan_idx_next;
    logic [CNTW-1:0]       issue_left_reg, issue_left_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [15:0]           found_coll_reg, found_coll_next;
    logic [31:0]           found_intid_reg, found_intid_next;

    logic [NW-1:0]         ncol;
    logic                  col_in_range;
    logic                  tgt_in_range;
    logic                  found_in_range;
    logic [CW-1:0]         cmd_col_idx;
    logic [CW-1:0]         found_col_idx;
    logic                  key_match;

    logic                  key_we;
    logic [95:0]           key_wdata;
    logic [95:0]           key_rdata;
    logic                  mcol_we;
    logic [AW-1:0]         mcol_waddr;
    logic [15:0]           mcol_rdata;
    logic                  cpu_we;
    logic [CW-1:0]         cpu_raddr;
    logic [3:0]            cpu_rdata;

    assign ncol = (32'(num_cpus_reg) > 32'(MAX_CPUS)) ? NW'(MAX_CPUS) : NW'(num_cpus_reg);
    assign col_in_range   = 32'(cmd_reg.collection_id) < 32'(ncol);
    assign tgt_in_range   = cmd_reg.target_cpu < 32'(ncol);
    assign found_in_range = 32'(found_coll_reg) < 32'(ncol);
    assign cmd_col_idx    = cmd_reg.collection_id[CW-1:0];
    assign found_col_idx  = found_coll_reg[CW-1:0];
    assign key_match      = (key_rdata[95:32] == {cmd_reg.device_id, cmd_reg.event_id});
    assign key_wdata      = {cmd_reg.device_id, cmd_reg.event_id,
                             (cmd_reg.op == itcu_pkg::OP_MAPTI) ? cmd_reg.phys_intid
                                                                : cmd_reg.event_id};
    assign cpu_raddr      = (state_reg == ST_SCAN) ? mcol_rdata[CW-1:0] : found_col_idx;

    itcu_ram #(.WIDTH(96), .DEPTH(MAX_MAPPINGS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (map_count_reg[AW-1:0]),
        .wdata (key_wdata),
        .raddr (scan_idx_reg),
        .rdata (key_rdata)
    );

    itcu_ram #(.WIDTH(16), .DEPTH(MAX_MAPPINGS)) u_mcol_ram (
        .clk   (clk),
        .we    (mcol_we),
        .waddr (mcol_waddr),
        .wdata (cmd_reg.collection_id),
        .raddr (scan_idx_reg),
        .rdata (mcol_rdata)
    );

    itcu_ram #(.WIDTH(4), .DEPTH(MAX_CPUS)) u_cpu_ram (
        .clk   (clk),
        .we    (cpu_we),
        .waddr (cmd_col_idx),
        .wdata (cmd_reg.target_cpu[3:0]),
        .raddr (cpu_raddr),
        .rdata (cpu_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        num_cpus_next    = num_cpus_reg;
        dev_entries_next = dev_entries_reg;
        coll_mapped_next = coll_mapped_reg;
        map_count_next   = map_count_reg;
        scan_idx_next    = scan_idx_reg;
        issue_left_next  = issue_left_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        found_coll_next  = found_coll_reg;
        found_intid_next = found_intid_reg;
        key_we           = 1'b0;
        mcol_we          = 1'b0;
        mcol_waddr       = map_count_reg[AW-1:0];
        cpu_we           = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                itcu_pkg::CFG_NUM_CPUS:  num_cpus_next    = cfg_data[4:0];
                itcu_pkg::CFG_DEV_TABLE: dev_entries_next = cfg_data;
                default:                 ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next.op            = cmd.op;
                    cmd_next.device_id     = cmd.device_id;
                    cmd_next.event_id      = cmd.event_id;
                    cmd_next.phys_intid    = cmd.phys_intid;
                    cmd_next.collection_id = cmd.collection_id;
                    cmd_next.target_cpu    = cmd.target_cpu;
                    cmd_next.map_valid_bit = cmd.map_valid_bit;
                    state_next             = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_next   = '0;
                res_next.status = 1'b1;
                state_next = ST_DONE;
                unique case (cmd_reg.op)
                    itcu_pkg::OP_MOVI, itcu_pkg::OP_MSI:
                    begin
                        if (map_count_reg != '0)
                        begin
                            scan_idx_next   = AW'(map_count_reg - 1'b1);
                            issue_left_next = map_count_reg;
                            state_next      = ST_SCAN;
                        end
                    end
                    itcu_pkg::OP_SYNC, itcu_pkg::OP_INV, itcu_pkg::OP_INVALL:
                    begin
                        res_next.status = 1'b0;
                    end
                    itcu_pkg::OP_MAPD:
                    begin
                        res_next.status = !(cmd_reg.device_id < itcu_pkg::DEV_ID_LIMIT &&
                                            cmd_reg.device_id < 32'(dev_entries_reg));
                    end
                    itcu_pkg::OP_MAPC:
                    begin
                        if (col_in_range)
                        begin
                            if (cmd_reg.map_valid_bit)
                            begin
                                if (tgt_in_range && !coll_mapped_reg[cmd_col_idx])
                                begin
                                    coll_mapped_next[cmd_col_idx] = 1'b1;
                                    cpu_we                        = 1'b1;
                                    res_next.status               = 1'b0;
                                end
                            end
                            else
                            begin
                                coll_mapped_next[cmd_col_idx] = 1'b0;
                                res_next.status               = 1'b0;
                            end
                        end
                    end
                    itcu_pkg::OP_MAPTI, itcu_pkg::OP_MAPI:
                    begin
                        if (32'(map_count_reg) < 32'(MAX_MAPPINGS))
                        begin
                            key_we          = 1'b1;
                            mcol_we         = 1'b1;
                            map_count_next  = map_count_reg + 1'b1;
                            res_next.status = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            ST_SCAN:
            begin
                if (issue_left_reg != '0)
                begin
                    rd_valid_next   = 1'b1;
                    rd_idx_next     = scan_idx_reg;
                    scan_idx_next   = scan_idx_reg - 1'b1;
                    issue_left_next = issue_left_reg - 1'b1;
                end
                if (rd_valid_reg && key_match)
                begin
                    rd_valid_next    = 1'b0;
                    found_coll_next  = mcol_rdata;
                    found_intid_next = key_rdata[31:0];
                    if (cmd_reg.op == itcu_pkg::OP_MOVI)
                    begin
                        mcol_we         = 1'b1;
                        mcol_waddr      = rd_idx_reg;
                        res_next.status = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CPU_RD;
                    end
                end
                else if (!rd_valid_reg && issue_left_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_CPU_RD:
            begin
                if (found_in_range && coll_mapped_reg[found_col_idx])
                begin
                    res_next.status       = 1'b0;
                    res_next.inject_valid = 1'b1;
                    res_next.inject_cpu   = cpu_rdata;
                    res_next.inject_intid = found_intid_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
            num_cpus_reg    <= 5'd1;
            dev_entries_reg <= '0;
            coll_mapped_reg <= '0;
            map_count_reg   <= '0;
            issue_left_reg  <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_reg         <= out_next;
            out_valid_reg   <= out_valid_next;
            num_cpus_reg    <= num_cpus_next;
            dev_entries_reg <= dev_entries_next;
            coll_mapped_reg <= coll_mapped_next;
            map_count_reg   <= map_count_next;
            issue_left_reg  <= issue_left_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        res_reg         <= res_next;
        scan_idx_reg    <= scan_idx_next;
        rd_idx_reg      <= rd_idx_next;
        found_coll_reg  <= found_coll_next;
        found_intid_reg <= found_intid_next;
    end

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.inject_valid = out_reg.inject_valid;
    assign rsp.inject_cpu   = out_reg.inject_cpu;
    assign rsp.inject_intid = out_reg.inject_intid;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(map_count_reg) <= 32'(MAX_MAPPINGS))
        else $error("mapping count beyond table size");

    a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EXEC) |=> $stable(map_count_reg))
        else $error("mapping count changed outside command execution");

    a_scan_idx_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && rd_valid_reg) |-> (32'(rd_idx_reg) < 32'(map_count_reg)))
        else $error("search read beyond filled mappings");

    a_inject_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.inject_valid) |-> !rsp.status)
        else $error("injection reported with failure status");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Interrupt translation command unit testbench
// Drives decoded translation commands and MSIs through the command channel,
// predicts each response from a behavioral copy of the collection and mapping
// tables, and compares every response beat field by field. Covers a directed
// pass over the corner cases, then random command streams under several
// num_cpus / dev_table_entries settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
class its_tracker;

    localparam int N_COLL = 16;
    localparam int N_MAP  = 64;

    logic [4:0]      num_cpus    = 5'd1;
    logic [21:0]     dev_entries = 22'd0;
    logic            coll_mapped [N_COLL];
    logic [3:0]      coll_cpu    [N_COLL];
    logic [63:0]     map_key     [N_MAP];
    logic [31:0]     map_intid   [N_MAP];
    logic [15:0]     map_coll    [N_MAP];
    int unsigned     map_count   = 0;
    itcu_pkg::rsp_t  awaited_responses [$];
    int unsigned     errors      = 0;

    function new();
        foreach (coll_mapped[i]) coll_mapped[i] = 1'b0;
    endfunction

    function void set_register(logic [itcu_pkg::CFG_IDX_W-1:0] index,
                               logic [itcu_pkg::CFG_DATA_W-1:0] data);
        if (index == itcu_pkg::CFG_NUM_CPUS)
            num_cpus = data[4:0];
        else
            dev_entries = data;
    endfunction

    function int newest_match(logic [63:0] key);
        for (int i = int'(map_count) - 1; i >= 0; i--)
            if (map_key[i] == key)
                return i;
        return -1;
    endfunction

    function itcu_pkg::rsp_t translate(itcu_pkg::cmd_t c);
        itcu_pkg::rsp_t r;
        logic [63:0]    key;
        int unsigned    ncol;
        int             idx;
        logic           ok;
        logic [15:0]    coll;
        r    = '0;
        ok   = 1'b0;
        key  = {c.device_id, c.event_id};
        ncol = (num_cpus > N_COLL) ? N_COLL : num_cpus;
        case (c.op)
            itcu_pkg::OP_MOVI:
            begin
                idx = newest_match(key);
                if (idx >= 0)
                begin
                    map_coll[idx] = c.collection_id;
                    ok = 1'b1;
                end
            end
            itcu_pkg::OP_SYNC, itcu_pkg::OP_INV, itcu_pkg::OP_INVALL:
                ok = 1'b1;
            itcu_pkg::OP_MAPD:
                ok = (c.device_id < itcu_pkg::DEV_ID_LIMIT) &&
                     (c.device_id < 32'(dev_entries));
            itcu_pkg::OP_MAPC:
            begin
                if (c.collection_id < ncol)
                begin
                    if (c.map_valid_bit)
                    begin
                        if (c.target_cpu < ncol && !coll_mapped[c.collection_id[3:0]])
                        begin
                            coll_mapped[c.collection_id[3:0]] = 1'b1;
                            coll_cpu[c.collection_id[3:0]]    = c.target_cpu[3:0];
                            ok = 1'b1;
                        end
                    end
                    else
                    begin
                        coll_mapped[c.collection_id[3:0]] = 1'b0;
                        ok = 1'b1;
                    end
                end
            end
            itcu_pkg::OP_MAPTI, itcu_pkg::OP_MAPI:
            begin
                if (map_count < N_MAP)
                begin
                    map_key[map_count]   = key;
                    map_intid[map_count] = (c.op == itcu_pkg::OP_MAPTI) ? c.phys_intid
                                                                         : c.event_id;
                    map_coll[map_count]  = c.collection_id;
                    map_count++;
                    ok = 1'b1;
                end
            end
            itcu_pkg::OP_MSI:
            begin
                idx = newest_match(key);
                if (idx >= 0)
                begin
                    coll = map_coll[idx];
                    if (coll < ncol && coll_mapped[coll[3:0]])
                    begin
                        r.inject_valid = 1'b1;
                        r.inject_cpu   = coll_cpu[coll[3:0]];
                        r.inject_intid = map_intid[idx];
                        ok = 1'b1;
                    end
                end
            end
            default:
                ok = 1'b0;
        endcase
        r.status = !ok;
        return r;
    endfunction

    function void note_command(itcu_pkg::cmd_t c);
        awaited_responses.push_back(translate(c));
    endfunction

    function int unsigned pending();
        return awaited_responses.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_response(itcu_pkg::rsp_t got);
        itcu_pkg::rsp_t want;
        if (awaited_responses.size() == 0)
        begin
            $error("response beat with no command outstanding: 0x%0h", got);
            errors++;
            return;
        end
        want = awaited_responses.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("inject_valid", 32'(want.inject_valid), 32'(got.inject_valid));
        compare_field("inject_cpu", 32'(want.inject_cpu), 32'(got.inject_cpu));
        compare_field("inject_intid", want.inject_intid, got.inject_intid);
    endfunction

endclass

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          CHUNKS       = 7;
    localparam int          CHUNK_ITEMS  = 250;
    localparam int unsigned CPU_SETTINGS [CHUNKS] = '{16, 0, 31, 8, 1, 5, 17};
    localparam int unsigned DEV_SETTINGS [CHUNKS] =
        '{4194303, 0, 65536, 2097152, 12, 65535, 2097152};

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [itcu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [itcu_pkg::CFG_DATA_W-1:0] cfg_data;
    int unsigned                     src_idle  = 10;
    int unsigned                     sink_idle = 75;
    int unsigned                     stall_cycles = 0;
    its_tracker                      tracker;

    itcu_cmd_if cmd_if ();
    itcu_rsp_if rsp_if ();

    interrupt_translation_command_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready = ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
            tracker.check_response({rsp_if.status, rsp_if.inject_valid,
                                    rsp_if.inject_cpu, rsp_if.inject_intid});
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [itcu_pkg::CFG_IDX_W-1:0] index,
                             input logic [itcu_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        tracker.set_register(index, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_cmd(input itcu_pkg::cmd_t c);
        while ($urandom_range(99) < src_idle)
        begin
            cmd_if.valid = 1'b0;
            @(negedge clk);
        end
        cmd_if.op            = c.op;
        cmd_if.device_id     = c.device_id;
        cmd_if.event_id      = c.event_id;
        cmd_if.phys_intid    = c.phys_intid;
        cmd_if.collection_id = c.collection_id;
        cmd_if.target_cpu    = c.target_cpu;
        cmd_if.map_valid_bit = c.map_valid_bit;
        cmd_if.valid         = 1'b1;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        tracker.note_command(c);
        @(negedge clk);
    endtask

    task automatic issue(input logic [3:0] op, input logic [31:0] dev, input logic [31:0] evt,
                         input logic [31:0] pid, input logic [15:0] coll,
                         input logic [31:0] tgt, input logic vbit);
        send_cmd('{op: op, device_id: dev, event_id: evt, phys_intid: pid,
                   collection_id: coll, target_cpu: tgt, map_valid_bit: vbit});
    endtask

    // Hold off until every response beat is back and the unit is idle.
    task automatic wait_idle();
        cmd_if.valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    function automatic itcu_pkg::cmd_t random_command();
        itcu_pkg::cmd_t c;
        int unsigned    pick;
        pick = $urandom_range(99);
        c.op = (pick < 34) ? itcu_pkg::OP_MSI   :
               (pick < 50) ? itcu_pkg::OP_MAPC  :
               (pick < 56) ? itcu_pkg::OP_MAPTI :
               (pick < 60) ? itcu_pkg::OP_MAPI  :
               (pick < 72) ? itcu_pkg::OP_MOVI  :
               (pick < 82) ? itcu_pkg::OP_MAPD  :
               (pick < 86) ? itcu_pkg::OP_SYNC  :
               (pick < 90) ? itcu_pkg::OP_INV   :
               (pick < 94) ? itcu_pkg::OP_INVALL : 4'($urandom_range(15, 9));
        c.device_id = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(5);
        if (c.op == itcu_pkg::OP_MAPD)
        begin
            case ($urandom_range(3))
                0: c.device_id = 32'(tracker.dev_entries) - 32'd1 + $urandom_range(2);
                1: c.device_id = itcu_pkg::DEV_ID_LIMIT - 32'd1 + $urandom_range(2);
                2: c.device_id = $urandom();
                default: c.device_id = $urandom_range(5);
            endcase
        end
        c.event_id      = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(3);
        c.phys_intid    = $urandom();
        c.collection_id = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(17));
        c.target_cpu    = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(17);
        c.map_valid_bit = ($urandom_range(99) < 65);
        return c;
    endfunction

    initial
    begin
        tracker              = new();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.op            = itcu_pkg::OP_SYNC;
        cmd_if.device_id     = '0;
        cmd_if.event_id      = '0;
        cmd_if.phys_intid    = '0;
        cmd_if.collection_id = '0;
        cmd_if.target_cpu    = '0;
        cmd_if.map_valid_bit = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(itcu_pkg::CFG_NUM_CPUS, 22'd16);
        write_reg(itcu_pkg::CFG_DEV_TABLE, 22'd65537);

        issue(itcu_pkg::OP_SYNC, 0, 0, 0, 0, 0, 0);
        issue(itcu_pkg::OP_INV, 0, 0, 0, 0, 0, 0);
        issue(itcu_pkg::OP_INVALL, 0, 0, 0, 0, 0, 0);
        issue(4'd9, 32'hFFFF_FFFF, 0, 0, 0, 0, 1);
        issue(4'd15, 0, 32'hFFFF_FFFF, 0, 16'hFFFF, 32'hFFFF_FFFF, 1);
        issue(itcu_pkg::OP_MAPD, 32'd65536, 0, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPD, 32'd65535, 0, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd16, 32'd0, 1);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd0, 32'd15, 1);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd0, 32'd1, 1);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd1, 32'd16, 1);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd15, 32'hFFFF_FFFF, 1);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd15, 32'd3, 1);
        issue(itcu_pkg::OP_MSI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPTI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd15, 0, 0);
        issue(itcu_pkg::OP_MSI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPI, 0, 32'h8000_0000, 0, 16'd0, 0, 0);
        issue(itcu_pkg::OP_MSI, 0, 32'h8000_0000, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPTI, 0, 32'h8000_0000, 32'h0000_1234, 16'd2, 0, 0);
        issue(itcu_pkg::OP_MSI, 0, 32'h8000_0000, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MOVI, 0, 32'h8000_0000, 0, 16'd0, 0, 0);
        issue(itcu_pkg::OP_MSI, 0, 32'h8000_0000, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MOVI, 32'd7, 32'd7, 0, 16'd1, 0, 0);
        issue(itcu_pkg::OP_MAPTI, 32'd1, 32'd1, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
        issue(itcu_pkg::OP_MSI, 32'd1, 32'd1, 0, 0, 0, 0);
        issue(itcu_pkg::OP_MAPC, 0, 0, 0, 16'd0, 0, 0);
        issue(itcu_pkg::OP_MSI, 0, 32'h8000_0000, 0, 0, 0, 0);

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            wait_idle();
            src_idle  = (chunk < 2) ? 10 : (chunk < 4) ? 75 : 0;
            sink_idle = (chunk < 2) ? 75 : (chunk < 4) ? 10 : 0;
            write_reg(itcu_pkg::CFG_NUM_CPUS, 22'(CPU_SETTINGS[chunk]));
            write_reg(itcu_pkg::CFG_DEV_TABLE, 22'(DEV_SETTINGS[chunk]));
            repeat (CHUNK_ITEMS) send_cmd(random_command());
        end

        wait_idle();
        repeat (100) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
